### src/fifo_replacement_lookup_cache_unit_macros.svh
// Assertion macros for the file that checks its own behavior.
`ifndef FIFO_REPLACEMENT_LOOKUP_CACHE_UNIT_MACROS_SVH
`define FIFO_REPLACEMENT_LOOKUP_CACHE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FRLC_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("frlc assertion failed");
`define FRLC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("frlc assertion failed");
`else
`define FRLC_ASSERT_SAME(label, clk, rst, cond, prop)
`define FRLC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

### src/frlc_pkg.sv
package frlc_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int KEY_BITS_DEFAULT = 10;
   localparam int CAP_BITS = 8;
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(128);
   localparam int MISS_BITS = 16;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
      logic load;
   } frlc_cmd_type;

   typedef struct packed {
      logic match;
      logic exhausted;
      logic rsp_free;
   } frlc_status_type;

endpackage

### src/frlc_channels.sv
interface frlc_req_if #(
   parameter int KEY_BITS = frlc_pkg::KEY_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [KEY_BITS-1:0] word_key;
   logic                last_word;

   modport source (output valid, output word_key, output last_word, input ready);
   modport sink (input valid, input word_key, input last_word, output ready);
endinterface

interface frlc_rsp_if;
   import frlc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [MISS_BITS-1:0] miss_count;
   logic                 final_res;

   modport source (output valid, output hit, output miss_count, output final_res,
                   input ready);
   modport sink (input valid, input hit, input miss_count, input final_res,
                 output ready);
endinterface

### src/frlc_ram.sv
module frlc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] address,
   input  logic [WIDTH-1:0]  write_data,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[address];
      end
   end

   assign read_data = read_data_ff;

endmodule

### src/frlc_datapath.sv
module frlc_datapath #(
   parameter int DEPTH = frlc_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = frlc_pkg::KEY_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  frlc_pkg::frlc_cmd_type           cmd,
   output frlc_pkg::frlc_status_type        status,
   input  logic [KEY_BITS-1:0]              req_key,
   input  logic                             req_last,
   input  logic                             csr_write_enable,
   input  logic [frlc_pkg::CAP_BITS-1:0]    csr_write_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [frlc_pkg::MISS_BITS-1:0]   rsp_miss_count,
   output logic                             rsp_final
);
   import frlc_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

   logic [CAP_BITS-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [ADDR_W-1:0]    oldest_ff, oldest_in;
   logic [MISS_BITS-1:0] misses_ff, misses_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic                 last_ff, last_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [MISS_BITS-1:0] rsp_miss_ff, rsp_miss_in;
   logic                 rsp_final_ff, rsp_final_in;

   logic [CNT_W-1:0]    eff_cap;
   logic [CNT_W-1:0]    limit;
   logic [CNT_W-1:0]    slot_wide;
   logic [CNT_W-1:0]    slot_next;
   logic [ADDR_W-1:0]   slot;
   logic                append;
   logic                read_enable;
   logic [ADDR_W-1:0]   address;
   logic [KEY_BITS-1:0] read_key;
   logic                match;

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (CW'(cap_ff) > CW'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
      limit = (fill_ff < eff_cap) ? fill_ff : eff_cap;
      append = fill_ff < eff_cap;
      slot_wide = (CNT_W'(oldest_ff) >= eff_cap) ? '0 : CNT_W'(oldest_ff);
      slot = slot_wide[ADDR_W-1:0];
      slot_next = slot_wide + CNT_W'(1);
      read_enable = cmd.scan && (issue_ff < limit);
      match = pend_ff && (read_key == key_ff);
      if (cmd.commit) begin
         address = append ? fill_ff[ADDR_W-1:0] : slot;
      end else begin
         address = issue_ff[ADDR_W-1:0];
      end
   end

   frlc_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_key_ram (
      .clock       (clock),
      .write_enable(cmd.commit),
      .read_enable (read_enable),
      .address     (address),
      .write_data  (key_ff),
      .read_data   (read_key)
   );

   always_comb begin
      cap_in = cap_ff;
      fill_in = fill_ff;
      oldest_in = oldest_ff;
      misses_in = misses_ff;
      key_in = key_ff;
      last_in = last_ff;
      issue_in = issue_ff;
      pend_in = pend_ff;
      hit_in = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_miss_in = rsp_miss_ff;
      rsp_final_in = rsp_final_ff;

      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end
      if (cmd.start) begin
         key_in = req_key;
         last_in = req_last;
         issue_in = '0;
         pend_in = 1'b0;
         hit_in = 1'b0;
      end
      if (cmd.scan) begin
         pend_in = read_enable;
         if (read_enable) begin
            issue_in = issue_ff + CNT_W'(1);
         end
         if (match) begin
            hit_in = 1'b1;
         end
      end
      if (cmd.commit) begin
         if (append) begin
            fill_in = fill_ff + CNT_W'(1);
         end else begin
            oldest_in = (slot_next >= eff_cap) ? '0 : slot_next[ADDR_W-1:0];
         end
         if (misses_ff != '1) begin
            misses_in = misses_ff + MISS_BITS'(1);
         end
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in = hit_ff;
         rsp_miss_in = misses_ff;
         rsp_final_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
         fill_ff <= '0;
         oldest_ff <= '0;
         misses_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff <= cap_in;
         fill_ff <= fill_in;
         oldest_ff <= oldest_in;
         misses_ff <= misses_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff <= key_in;
      last_ff <= last_in;
      issue_ff <= issue_in;
      hit_ff <= hit_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_miss_ff <= rsp_miss_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign status.match = cmd.scan && match;
   assign status.exhausted = cmd.scan && (issue_ff >= limit) && !match;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_miss_count = rsp_miss_ff;
   assign rsp_final = rsp_final_ff;

endmodule

### src/frlc_controller.sv
module frlc_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  frlc_pkg::frlc_status_type status,
   output frlc_pkg::frlc_cmd_type    cmd
);
   import frlc_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      UPDATE,
      RESPOND
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = (state_ff == IDLE);
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (status.match) begin
               state_in = RESPOND;
            end else if (status.exhausted) begin
               state_in = UPDATE;
            end
         end
         UPDATE: begin
            cmd.commit = 1'b1;
            state_in = RESPOND;
         end
         RESPOND: begin
            if (status.rsp_free) begin
               cmd.load = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/fifo_replacement_lookup_cache_unit.sv
// Fully associative key store with first-in-first-out replacement and a saturating
// miss counter. Each request word carries one key and returns one response word with
// the hit flag, the miss count including this word, and an echo of last_word. Keys
// live in a single-port memory that is scanned one entry per cycle over the smaller
// of the filled entry count and the effective capacity; a hit ends the scan early,
// and a miss writes the key over the oldest entry or into a free one before the
// response is loaded. One word is processed at a time; the next word is taken
// while the previous response still waits. The capacity register (reset 128) may be
// written only while the block is idle; zero acts as one and values above DEPTH act
// as DEPTH.
module fifo_replacement_lookup_cache_unit #(
   parameter int DEPTH = frlc_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = frlc_pkg::KEY_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   frlc_req_if.sink                      req_channel,
   frlc_rsp_if.source                    rsp_channel,
   input  logic                          csr_write_enable,
   input  logic [frlc_pkg::CAP_BITS-1:0] csr_write_data
);
   import frlc_pkg::*;

`include "fifo_replacement_lookup_cache_unit_macros.svh"

   frlc_cmd_type    cmd;
   frlc_status_type status;
   logic            req_ready;

   frlc_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_channel.valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   frlc_datapath #(
      .DEPTH   (DEPTH),
      .KEY_BITS(KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_key         (req_channel.word_key),
      .req_last        (req_channel.last_word),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_channel.valid),
      .rsp_ready       (rsp_channel.ready),
      .rsp_hit         (rsp_channel.hit),
      .rsp_miss_count  (rsp_channel.miss_count),
      .rsp_final       (rsp_channel.final_res)
   );

   assign req_channel.ready = req_ready;

   `FRLC_ASSERT_NEXT(busy_after_accept, clock, reset, req_channel.valid && req_ready, !req_ready)
   `FRLC_ASSERT_NEXT(load_shows_word, clock, reset, cmd.load, rsp_channel.valid)
   `FRLC_ASSERT_SAME(match_ends_scan, clock, reset, status.match, !status.exhausted)
   `FRLC_ASSERT_SAME(commit_not_hit, clock, reset, cmd.commit, !cmd.load && !req_ready)

endmodule
